// ===== src/ehcl_pkg.sv =====
// ============================================================================
// ehcl_pkg
// Shared types and constants for the Ethernet header classifier and MAC
// learning chain.
// ============================================================================
package ehcl_pkg;

    // Known EtherType values
    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_ARP       = 16'h0806;
    localparam logic [15:0] ET_RARP      = 16'h8035;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;
    localparam logic [15:0] ET_MPLS      = 16'h8847;
    localparam logic [15:0] ET_PPPOE_DIS = 16'h8863;
    localparam logic [15:0] ET_PPPOE_SES = 16'h8864;
    localparam logic [15:0] ET_VLAN      = 16'h8100;

    // Upper kind codes
    localparam logic [2:0] UK_NONE      = 3'd0;
    localparam logic [2:0] UK_ARP       = 3'd1;
    localparam logic [2:0] UK_RARP      = 3'd2;
    localparam logic [2:0] UK_MPLS      = 3'd3;
    localparam logic [2:0] UK_PPPOE_DIS = 3'd4;
    localparam logic [2:0] UK_PPPOE_SES = 3'd5;
    localparam logic [2:0] UK_VLAN      = 3'd6;

    // Network kind codes
    localparam logic [1:0] NK_NONE = 2'd0;
    localparam logic [1:0] NK_IPV4 = 2'd1;
    localparam logic [1:0] NK_IPV6 = 2'd2;

    // Link kind codes
    localparam logic LK_ETH2  = 1'b0;
    localparam logic LK_IEEE3 = 1'b1;

    // Payload offsets and header overheads
    localparam logic [4:0]  OFFSET_ETH2  = 5'd14;
    localparam logic [4:0]  OFFSET_IEEE3 = 5'd22;
    localparam logic [15:0] OVERHEAD_ETH2  = 16'd18;
    localparam logic [15:0] OVERHEAD_IEEE3 = 16'd8;

    // Reported slot number width
    localparam int unsigned SLOT_W = 6;

    // Classification result carried alongside the source lookup
    typedef struct packed {
        logic        link_kind;
        logic [2:0]  upper_kind;
        logic [1:0]  network_kind;
        logic [4:0]  payload_offset;
        logic [15:0] payload_size;
    } t_cls;

    // Lookup token that walks the cell chain
    typedef struct packed {
        logic        valid;
        logic        is_src;
        logic [47:0] key;
        logic        hit;
        logic        is_new;
        t_cls        cls;
    } t_token;

endpackage

// ===== src/ethernet_header_classify_learn.sv =====
// ============================================================================
// ethernet_header_classify_learn
// Classifies one Ethernet header per beat and learns the destination and
// source MAC addresses in a chain of table cells.
// ============================================================================
//  channel   direction  handshake               payload
//  s (in)    slave      i_s_tvalid/o_s_tready   i_s_tdata 144 bits, header
//  m (out)   master     o_m_tvalid/i_m_tready   o_m_tdata 48 bits, result
//
//  An input beat injects a destination token and then a source token into
//  the cell chain; no new header is taken until its source token is in.
//  Each token walks one cell a cycle while the chain is not halted; a result
//  is registered once its source token has passed the whole cell chain.
//  Reset empties the table at once; no clearing pass is needed.
//  The chain halts only when a finished source token meets a held result;
//  input beats are still taken while a result waits and the chain moves.
// ============================================================================
module ethernet_header_classify_learn #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // fields from bit 0: frame_length[15:0], dest_mac[63:16],
    // src_mac[111:64], ether_type[127:112], snap_type[143:128]
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // fields from bit 0: link_kind[0], upper_kind[3:1], network_kind[5:4],
    // payload_offset[10:6], payload_size[26:11], dest_index[32:27],
    // dest_new[33], src_index[39:34], src_new[40], table_full[41], zeros
    output logic [47:0]  o_m_tdata
);
    import ehcl_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    // Head: held header for the source token
    logic        r_phase;
    logic [15:0] r_frame_length;
    logic [47:0] r_src_mac;
    logic [15:0] r_ether_type;
    logic [15:0] r_snap_type;
    t_cls        w_cls;

    logic        w_en;
    logic        w_accept;
    t_token      w_tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0] w_idx [TABLE_DEPTH+1];
    t_token      w_last;

    // Tail: destination result and output register
    logic             r_dest_hit;
    logic             r_dest_new;
    logic [IDX_W-1:0] r_dest_idx;
    logic             r_out_valid;
    logic [47:0]      r_out_data;
    logic [IDX_W+SLOT_W-1:0] w_dext;
    logic [IDX_W+SLOT_W-1:0] w_sext;
    logic [47:0]      n_out_data;

    assign w_last     = w_tok[TABLE_DEPTH];
    assign w_en       = !(w_last.valid && w_last.is_src && r_out_valid && !i_m_tready);
    assign o_s_tready = w_en && !r_phase;
    assign w_accept   = i_s_tvalid && o_s_tready;

    ehcl_classify u_classify (
        .i_frame_length (r_frame_length),
        .i_ether_type   (r_ether_type),
        .i_snap_type    (r_snap_type),
        .o_cls          (w_cls)
    );

    // Inject the destination token on accept, the source token next
    always_comb begin
        w_tok[0] = '0;
        w_idx[0] = '0;
        if (r_phase) begin
            w_tok[0].valid  = 1'b1;
            w_tok[0].is_src = 1'b1;
            w_tok[0].key    = r_src_mac;
            w_tok[0].cls    = w_cls;
        end else if (w_accept) begin
            w_tok[0].valid  = 1'b1;
            w_tok[0].key    = i_s_tdata[63:16];
        end
    end

    // Track the injection phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (w_en) begin
            r_phase <= w_accept;
        end
    end

    // Hold the header fields for the source token
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame_length <= i_s_tdata[15:0];
            r_src_mac      <= i_s_tdata[111:64];
            r_ether_type   <= i_s_tdata[127:112];
            r_snap_type    <= i_s_tdata[143:128];
        end
    end

    // Chain of table cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ehcl_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (IDX_W'(g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .i_idx   (w_idx[g]),
            .o_tok   (w_tok[g+1]),
            .o_idx   (w_idx[g+1])
        );
    end

    // Build the result word from both lookups
    always_comb begin
        w_dext     = {{SLOT_W{1'b0}}, r_dest_idx};
        w_sext     = {{SLOT_W{1'b0}}, w_idx[TABLE_DEPTH]};
        n_out_data = '0;
        n_out_data[0]     = w_last.cls.link_kind;
        n_out_data[3:1]   = w_last.cls.upper_kind;
        n_out_data[5:4]   = w_last.cls.network_kind;
        n_out_data[10:6]  = w_last.cls.payload_offset;
        n_out_data[26:11] = w_last.cls.payload_size;
        n_out_data[32:27] = w_dext[SLOT_W-1:0];
        n_out_data[33]    = r_dest_new;
        n_out_data[39:34] = w_sext[SLOT_W-1:0];
        n_out_data[40]    = w_last.is_new;
        n_out_data[41]    = !r_dest_hit || !w_last.hit;
    end

    // Output valid: set on a source token, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_last.valid && w_last.is_src) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture destination lookup and result payload
    always_ff @(posedge i_clk) begin
        if (w_en && w_last.valid) begin
            if (w_last.is_src) begin
                r_out_data <= n_out_data;
            end else begin
                r_dest_hit <= w_last.hit;
                r_dest_new <= w_last.is_new;
                r_dest_idx <= w_idx[TABLE_DEPTH];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A destination token leaving the chain is followed by its source token
    a_dest_then_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_last.valid && !w_last.is_src) |=> (w_last.valid && w_last.is_src))
        else $error("source token does not follow destination token");

    // Two source tokens never leave back to back
    a_no_double_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_last.valid && w_last.is_src) |=> !(w_last.valid && w_last.is_src))
        else $error("two source tokens in a row at chain end");

    // Two fresh inserts by one header take distinct slots
    a_distinct_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[33] && r_out_data[40]) |->
        (r_out_data[32:27] != r_out_data[39:34]))
        else $error("destination and source inserted into the same slot");

    // A result never claims both inserts and a full table
    a_full_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[41]) |-> !(r_out_data[33] && r_out_data[40]))
        else $error("table full reported with both addresses inserted");

endmodule

// ===== src/ehcl_classify.sv =====
// ============================================================================
// ehcl_classify
// Maps the type/length and SNAP type fields to link, upper and network
// kinds, and works out the payload offset and saturated payload size.
// ============================================================================
module ehcl_classify (
    input  logic [15:0]   i_frame_length,
    input  logic [15:0]   i_ether_type,
    input  logic [15:0]   i_snap_type,
    output ehcl_pkg::t_cls o_cls
);
    import ehcl_pkg::*;

    typedef struct packed {
        logic       known;
        logic [2:0] upper;
        logic [1:0] net;
    } t_kind;

    function automatic t_kind lookup(input logic [15:0] t);
        t_kind k;
        k = '{known: 1'b1, upper: UK_NONE, net: NK_NONE};
        case (t)
            ET_IPV4:      k.net   = NK_IPV4;
            ET_ARP:       k.upper = UK_ARP;
            ET_RARP:      k.upper = UK_RARP;
            ET_IPV6:      k.net   = NK_IPV6;
            ET_MPLS:      k.upper = UK_MPLS;
            ET_PPPOE_DIS: k.upper = UK_PPPOE_DIS;
            ET_PPPOE_SES: k.upper = UK_PPPOE_SES;
            ET_VLAN:      k.upper = UK_VLAN;
            default:      k.known = 1'b0;
        endcase
        return k;
    endfunction

    t_kind w_eth;
    t_kind w_snap;

    // Classify both type fields
    assign w_eth  = lookup(i_ether_type);
    assign w_snap = lookup(i_snap_type);

    // Select framing and size the payload, saturating at zero
    always_comb begin
        if (w_eth.known) begin
            o_cls.link_kind      = LK_ETH2;
            o_cls.upper_kind     = w_eth.upper;
            o_cls.network_kind   = w_eth.net;
            o_cls.payload_offset = OFFSET_ETH2;
            o_cls.payload_size   = (i_frame_length >= OVERHEAD_ETH2) ?
                                   i_frame_length - OVERHEAD_ETH2 : 16'd0;
        end else begin
            o_cls.link_kind      = LK_IEEE3;
            o_cls.upper_kind     = w_snap.known ? w_snap.upper : UK_NONE;
            o_cls.network_kind   = w_snap.known ? w_snap.net : NK_NONE;
            o_cls.payload_offset = OFFSET_IEEE3;
            o_cls.payload_size   = (i_ether_type >= OVERHEAD_IEEE3) ?
                                   i_ether_type - OVERHEAD_IEEE3 : 16'd0;
        end
    end

endmodule

// ===== src/ehcl_cell.sv =====
// ============================================================================
// ehcl_cell
// One slot of the MAC learning chain: holds one address, matches a passing
// token against it, or claims the token's address when the slot is free.
// ============================================================================
module ehcl_cell #(
    parameter int unsigned IDX_W      = 6,
    parameter logic [IDX_W-1:0] CELL_INDEX = '0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ehcl_pkg::t_token    i_tok,
    input  logic [IDX_W-1:0]    i_idx,
    output ehcl_pkg::t_token    o_tok,
    output logic [IDX_W-1:0]    o_idx
);
    import ehcl_pkg::*;

    logic [47:0]      r_mac;
    logic             r_occ;
    t_token           r_tok;
    logic [IDX_W-1:0] r_idx;

    t_token           n_tok;
    logic [IDX_W-1:0] n_idx;
    logic             n_write;

    // Match against the stored address, or claim the first free slot
    always_comb begin
        n_tok   = i_tok;
        n_idx   = i_idx;
        n_write = 1'b0;
        if (i_tok.valid && !i_tok.hit) begin
            if (r_occ) begin
                if (r_mac == i_tok.key) begin
                    n_tok.hit = 1'b1;
                    n_idx     = CELL_INDEX;
                end
            end else begin
                n_tok.hit    = 1'b1;
                n_tok.is_new = 1'b1;
                n_idx        = CELL_INDEX;
                n_write      = 1'b1;
            end
        end
    end

    // Advance the token and mark the slot taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (n_write) begin
                r_occ <= 1'b1;
            end
        end
    end

    // Slot address and token index need no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
            if (n_write) begin
                r_mac <= i_tok.key;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule
